/* hdl/pfe_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
`default_nettype none

package pfe_pkg;

    // Input item: one character of the expression.
    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } pfe_in_t;

    // Result item: stack view after the character.
    typedef struct packed {
        logic signed [31:0] top_value;
        logic [4:0]         depth;
        logic [2:0]         error;
        logic               done_res;
    } pfe_out_t;

    typedef logic [2:0] err_t;

    localparam err_t ERR_OK    = 3'd0;
    localparam err_t ERR_FEW   = 3'd1;
    localparam err_t ERR_DIV0  = 3'd2;
    localparam err_t ERR_OVER  = 3'd3;
    localparam err_t ERR_EMPTY = 3'd4;

    // ASCII codes that the evaluator reacts to
    localparam logic [7:0] SYM_ZERO  = 8'd48;
    localparam logic [7:0] SYM_NINE  = 8'd57;
    localparam logic [7:0] SYM_PLUS  = 8'd43;
    localparam logic [7:0] SYM_MINUS = 8'd45;
    localparam logic [7:0] SYM_STAR  = 8'd42;
    localparam logic [7:0] SYM_SLASH = 8'd47;

    typedef logic [1:0] alu_op_t;

    localparam alu_op_t ALU_ADD = 2'd0;
    localparam alu_op_t ALU_SUB = 2'd1;
    localparam alu_op_t ALU_MUL = 2'd2;
    localparam alu_op_t ALU_DIV = 2'd3;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } alu_rsp_t;

endpackage

`default_nettype wire

/* hdl/pfe_stack.sv */
// Value stack storage: one write port, one registered read port.
`default_nettype none

module pfe_stack #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [31:0]       wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]            rd_data
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/pfe_alu.sv */
// Shared arithmetic unit: one-pass add/sub, 32-step shift-add multiply and
// restoring signed divide.
`default_nettype none

module pfe_alu (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pfe_pkg::alu_req_t req,
    input  wire logic [31:0]       lhs,
    input  wire logic [31:0]       rhs,
    output pfe_pkg::alu_rsp_t      rsp
);

    import pfe_pkg::*;

    logic        busy_reg, busy_next;
    logic        fin_reg, fin_next;
    logic        done_reg, done_next;
    alu_op_t     op_reg, op_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] acc_reg, acc_next;   // product or partial remainder
    logic [31:0] x_reg, x_next;       // multiplicand, or dividend/quotient
    logic [31:0] y_reg, y_next;       // multiplier, or divisor
    logic        neg_reg, neg_next;
    logic [31:0] res_reg, res_next;

    logic [31:0] mul_sum;
    logic [32:0] rem_sh;
    logic [33:0] diff;
    logic        q_bit;
    logic [31:0] abs_l, abs_r;

    assign mul_sum = acc_reg + (y_reg[0] ? x_reg : 32'd0);
    assign rem_sh  = {acc_reg, x_reg[31]};
    assign diff    = {1'b0, rem_sh} - {2'b00, y_reg};
    assign q_bit   = ~diff[33];
    assign abs_l   = lhs[31] ? (32'd0 - lhs) : lhs;
    assign abs_r   = rhs[31] ? (32'd0 - rhs) : rhs;

    always_comb begin
        busy_next = busy_reg;
        fin_next  = fin_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;

        if (req.start) begin
            op_next   = req.op;
            step_next = 5'd0;
            unique case (req.op)
                ALU_ADD: begin
                    res_next  = lhs + rhs;
                    done_next = 1'b1;
                end
                ALU_SUB: begin
                    res_next  = lhs - rhs;
                    done_next = 1'b1;
                end
                ALU_MUL: begin
                    acc_next  = 32'd0;
                    x_next    = lhs;
                    y_next    = rhs;
                    busy_next = 1'b1;
                end
                ALU_DIV: begin
                    acc_next  = 32'd0;
                    x_next    = abs_l;
                    y_next    = abs_r;
                    neg_next  = lhs[31] ^ rhs[31];
                    busy_next = 1'b1;
                end
                default: begin
                    done_next = 1'b1;
                end
            endcase
        end else if (fin_reg) begin
            // sign fix of the quotient; -2^31 / -1 wraps naturally
            res_next  = neg_reg ? (32'd0 - x_reg) : x_reg;
            done_next = 1'b1;
            fin_next  = 1'b0;
        end else if (busy_reg) begin
            step_next = step_reg + 5'd1;
            if (op_reg == ALU_MUL) begin
                acc_next = mul_sum;
                x_next   = {x_reg[30:0], 1'b0};
                y_next   = {1'b0, y_reg[31:1]};
                if (step_reg == 5'd31) begin
                    busy_next = 1'b0;
                    res_next  = mul_sum;
                    done_next = 1'b1;
                end
            end else begin
                acc_next = q_bit ? diff[31:0] : rem_sh[31:0];
                x_next   = {x_reg[30:0], q_bit};
                if (step_reg == 5'd31) begin
                    busy_next = 1'b0;
                    fin_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        step_reg <= step_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

`default_nettype wire

/* hdl/postfix_expression_evaluator.sv */
// Top level of the postfix (RPN) expression evaluator.
`default_nettype none

// Takes one ASCII character per input item and returns one result item for
// each. Digits '0'..'9' push their value; '+', '-', '*', '/' pop right then
// left operand and push the 32-bit signed result (wrapping; divide truncates
// toward zero); anything else is ignored. The item flagged last closes the
// expression: its result carries done_res when the stack holds a value, and
// the stack is emptied afterwards. Errors: too few operands, divide by zero
// and overflow leave the stack untouched; an empty stack at the end reports
// "empty at end". Digits, ignored characters and operators with too few
// operands go from accept straight to the output stage; other operators
// read the left operand from memory, then report a zero divisor or run on
// the shared arithmetic unit, which for multiply and divide retires one bit
// per cycle over 32 steps. One item is in flight at a time; s_ready is high
// whenever the sequencer is idle, also while a finished result waits in the
// output register. The stack top is mirrored in a register; all entries sit
// in a STACK_DEPTH-entry memory that needs no clearing after reset.

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pfe_pkg::pfe_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pfe_pkg::pfe_out_t     m_data
);

    import pfe_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;   // second operand read in flight
    localparam logic [1:0] ST_ALU  = 2'd2;   // waiting on arithmetic unit
    localparam logic [1:0] ST_FIN  = 2'd3;   // result ready for output reg

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      top_reg, top_next;     // mirror of stack[count-1]
    alu_op_t          op_reg, op_next;
    logic             last_reg, last_next;
    err_t             err_reg, err_next;
    logic             m_valid_reg, m_valid_next;
    pfe_out_t         out_reg, out_next;

    logic             is_digit, is_oper;
    alu_op_t          dec_op;
    logic [31:0]      digit_val;
    logic [CNT_W-1:0] cnt_m2;
    logic             has_val;
    logic [CNT_W+4:0] cnt_ext;

    logic             mem_wr_en, mem_rd_en;
    logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
    logic [31:0]      mem_wr_data, mem_rd_data;

    alu_req_t         alu_req;
    alu_rsp_t         alu_rsp;

    assign is_digit  = (s_data.symbol >= SYM_ZERO) && (s_data.symbol <= SYM_NINE);
    assign is_oper   = (s_data.symbol == SYM_PLUS) || (s_data.symbol == SYM_MINUS) ||
                       (s_data.symbol == SYM_STAR) || (s_data.symbol == SYM_SLASH);
    assign digit_val = {24'd0, s_data.symbol - SYM_ZERO};
    assign cnt_m2    = count_reg - CNT_W'(2);
    assign has_val   = (count_reg != '0);
    assign cnt_ext   = {5'd0, count_reg};

    always_comb begin
        unique case (s_data.symbol)
            SYM_PLUS:  dec_op = ALU_ADD;
            SYM_MINUS: dec_op = ALU_SUB;
            SYM_STAR:  dec_op = ALU_MUL;
            default:   dec_op = ALU_DIV;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        op_next      = op_reg;
        last_next    = last_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        mem_wr_en    = 1'b0;
        mem_wr_addr  = count_reg[IDX_W-1:0];
        mem_wr_data  = digit_val;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = cnt_m2[IDX_W-1:0];

        alu_req.start = 1'b0;
        alu_req.op    = op_reg;

        s_ready = (state_reg == ST_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next  = s_data.last;
                    err_next   = ERR_OK;
                    op_next    = dec_op;
                    state_next = ST_FIN;
                    if (is_digit) begin
                        if (count_reg == CNT_W'(STACK_DEPTH)) begin
                            err_next = ERR_OVER;
                        end else begin
                            mem_wr_en  = 1'b1;
                            top_next   = digit_val;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if (is_oper) begin
                        if (count_reg < CNT_W'(2)) begin
                            err_next = ERR_FEW;
                        end else begin
                            mem_rd_en  = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                // left operand now on mem_rd_data, right operand is top_reg
                if (op_reg == ALU_DIV && top_reg == 32'd0) begin
                    err_next   = ERR_DIV0;
                    state_next = ST_FIN;
                end else begin
                    alu_req.start = 1'b1;
                    state_next    = ST_ALU;
                end
            end
            ST_ALU: begin
                if (alu_rsp.done) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = cnt_m2[IDX_W-1:0];
                    mem_wr_data = alu_rsp.result;
                    top_next    = alu_rsp.result;
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.top_value = has_val ? top_reg : 32'd0;
                    out_next.depth     = cnt_ext[4:0];
                    out_next.done_res  = last_reg && has_val;
                    out_next.error     = (last_reg && !has_val && err_reg == ERR_OK) ?
                                         ERR_EMPTY : err_reg;
                    m_valid_next = 1'b1;
                    if (last_reg) begin
                        count_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg  <= top_next;
        op_reg   <= op_next;
        last_reg <= last_next;
        err_reg  <= err_next;
        out_reg  <= out_next;
    end

    pfe_stack #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (IDX_W)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    pfe_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .lhs     (mem_rd_data),
        .rhs     (top_reg),
        .rsp     (alu_rsp)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

/* hdl/pfe_checker.sv */
// Port-level checker for the postfix expression evaluator, with its bind.
`default_nettype none

module pfe_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire pfe_pkg::pfe_out_t m_data
);

    import pfe_pkg::*;

    // output item holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // one item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous item in work");

    // empty at end means nothing on the stack and no final result
    a_empty_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error == ERR_EMPTY |->
            m_data.depth == 5'd0 && m_data.top_value == 32'sd0 && !m_data.done_res)
        else $error("empty-at-end result inconsistent");

    // a final result never carries the empty error
    a_done_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.done_res |-> m_data.error != ERR_EMPTY)
        else $error("final result flagged empty");

    // no result item right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
